[hdl/ple_pkg.sv]
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 7;
	localparam int ENT_W    = 7;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_BITS   = VAL_W + 2 + ENT_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [3:0] {
		K_READ       = 4'd0,
		K_WRITE      = 4'd1,
		K_INSERT     = 4'd2,
		K_REMOVE     = 4'd3,
		K_READ_FIRST = 4'd4,
		K_READ_LAST  = 4'd5,
		K_INS_FIRST  = 4'd6,
		K_INS_LAST   = 4'd7,
		K_REM_FIRST  = 4'd8,
		K_REM_LAST   = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_WRITE = 2'd1,
		OP_INS   = 2'd2,
		OP_DEL   = 2'd3
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [VAL_W-1:0]  value;
	} cell_cmd_t;

	// decoded request from the controller
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
		status_t           status;
		logic [CNT_W-1:0]  cnt_next;
	} ctl_t;

endpackage

[hdl/ple_cell.sv]
module ple_cell (
	input  logic                           clk,
	input  logic [ple_pkg::IDX_W-1:0]      idx,
	input  ple_pkg::cell_cmd_t             cmd,
	input  logic [ple_pkg::VAL_W-1:0]      left,
	input  logic [ple_pkg::VAL_W-1:0]      right,
	output logic [ple_pkg::VAL_W-1:0]      data
);

	logic [ple_pkg::VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			ple_pkg::OP_WRITE: begin
				if (idx == cmd.pos) data_q <= cmd.value;
			end
			ple_pkg::OP_INS: begin
				// cells above the slot take their lower neighbor
				if (idx == cmd.pos) data_q <= cmd.value;
				else if (idx > cmd.pos) data_q <= left;
			end
			ple_pkg::OP_DEL: begin
				if (idx >= cmd.pos) data_q <= right;
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

[hdl/ple_ctrl.sv]
module ple_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [3:0]                     kind,
	input  logic [ple_pkg::POS_W-1:0]      position,
	output ple_pkg::ctl_t                  ctl
);

	logic [ple_pkg::CNT_W-1:0] count_q;
	logic [ple_pkg::CMP_W-1:0] pos_w;
	logic [ple_pkg::CMP_W-1:0] cnt_w;
	logic                      full;
	logic                      empty;
	logic [ple_pkg::IDX_W-1:0] last_idx;
	logic [ple_pkg::IDX_W-1:0] pos_idx;
	logic [ple_pkg::IDX_W-1:0] cnt_idx;

	assign pos_w    = ple_pkg::CMP_W'(position);
	assign cnt_w    = ple_pkg::CMP_W'(count_q);
	assign full     = (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_idx  = position[ple_pkg::IDX_W-1:0];
	assign cnt_idx  = count_q[ple_pkg::IDX_W-1:0];
	assign last_idx = cnt_idx - 1'b1;

	always_comb begin
		ctl.op       = ple_pkg::OP_NOP;
		ctl.pos      = '0;
		ctl.rd_en    = 1'b0;
		ctl.rd_idx   = '0;
		ctl.status   = ple_pkg::ST_OK;
		ctl.cnt_next = count_q;
		case (ple_pkg::kind_t'(kind))
			ple_pkg::K_READ: begin
				if (pos_w < cnt_w) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_idx = pos_idx;
				end else ctl.status = ple_pkg::ST_RANGE;
			end
			ple_pkg::K_WRITE: begin
				if (pos_w < cnt_w) begin
					ctl.op  = ple_pkg::OP_WRITE;
					ctl.pos = pos_idx;
				end else ctl.status = ple_pkg::ST_RANGE;
			end
			ple_pkg::K_INSERT: begin
				// range check wins over full
				if (pos_w > cnt_w) ctl.status = ple_pkg::ST_RANGE;
				else if (full) ctl.status = ple_pkg::ST_FULL;
				else begin
					ctl.op       = ple_pkg::OP_INS;
					ctl.pos      = pos_idx;
					ctl.cnt_next = count_q + 1'b1;
				end
			end
			ple_pkg::K_REMOVE: begin
				if (pos_w < cnt_w) begin
					ctl.op       = ple_pkg::OP_DEL;
					ctl.pos      = pos_idx;
					ctl.cnt_next = count_q - 1'b1;
				end else ctl.status = ple_pkg::ST_RANGE;
			end
			ple_pkg::K_READ_FIRST: begin
				if (!empty) ctl.rd_en = 1'b1;
				else ctl.status = ple_pkg::ST_EMPTY;
			end
			ple_pkg::K_READ_LAST: begin
				if (!empty) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_idx = last_idx;
				end else ctl.status = ple_pkg::ST_EMPTY;
			end
			ple_pkg::K_INS_FIRST: begin
				if (full) ctl.status = ple_pkg::ST_FULL;
				else begin
					ctl.op       = ple_pkg::OP_INS;
					ctl.cnt_next = count_q + 1'b1;
				end
			end
			ple_pkg::K_INS_LAST: begin
				if (full) ctl.status = ple_pkg::ST_FULL;
				else begin
					ctl.op       = ple_pkg::OP_INS;
					ctl.pos      = cnt_idx;
					ctl.cnt_next = count_q + 1'b1;
				end
			end
			ple_pkg::K_REM_FIRST: begin
				if (!empty) begin
					ctl.op       = ple_pkg::OP_DEL;
					ctl.cnt_next = count_q - 1'b1;
				end else ctl.status = ple_pkg::ST_EMPTY;
			end
			ple_pkg::K_REM_LAST: begin
				if (!empty) begin
					ctl.op       = ple_pkg::OP_DEL;
					ctl.pos      = last_idx;
					ctl.cnt_next = count_q - 1'b1;
				end else ctl.status = ple_pkg::ST_EMPTY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= ctl.cnt_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.status == ple_pkg::ST_FULL |-> full)
		else $error("full status without a full list");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.op == ple_pkg::OP_INS |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.status != ple_pkg::ST_OK |-> ctl.op == ple_pkg::OP_NOP && !ctl.rd_en)
		else $error("refused transaction touches the list");

endmodule

[hdl/positional_list_engine_top.sv]
// result: registered; it appears on the master side in the cycle after its transaction is accepted
// throughput: one transaction per cycle; cells from the position up shift in that same cycle
// the only stall is a result still held in the output register while m_tready is low
// reset: arst_n clears the entry count and the output valid; cell contents stay
// undefined until written and are never read before that
module positional_list_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ple_pkg::IN_DATA_W-1:0]       s_tdata,   // position, value_in
	input  logic [3:0]                          s_tuser,   // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ple_pkg::OUT_DATA_W-1:0]      m_tdata    // value_out, status, entry_count, is_empty
);

	logic                       accept;
	ple_pkg::ctl_t              ctl;
	ple_pkg::cell_cmd_t         cmd;
	logic [ple_pkg::VAL_W-1:0]  cell_data [ple_pkg::CAPACITY];
	logic [ple_pkg::VAL_W-1:0]  rd_val;
	logic [ple_pkg::VAL_W-1:0]  value_out;
	logic                       m_tvalid_q;
	logic [ple_pkg::OUT_DATA_W-1:0] m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (s_tuser),
		.position (s_tdata[ple_pkg::POS_W-1:0]),
		.ctl      (ctl)
	);

	assign cmd.op    = accept ? ctl.op : ple_pkg::OP_NOP;
	assign cmd.pos   = ctl.pos;
	assign cmd.value = s_tdata[ple_pkg::POS_W +: ple_pkg::VAL_W];

	for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
		logic [ple_pkg::VAL_W-1:0] left;
		logic [ple_pkg::VAL_W-1:0] right;
		if (i == 0) begin : g_first
			assign left = cell_data[i];
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == ple_pkg::CAPACITY - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end
		ple_cell u_cell (
			.clk   (clk),
			.idx   (ple_pkg::IDX_W'(i)),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	// each cell drives its word onto an or-bus when its index matches
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
			if (ctl.rd_idx == ple_pkg::IDX_W'(i)) rd_val = rd_val | cell_data[i];
		end
	end

	assign value_out = ctl.rd_en ? rd_val : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= ple_pkg::OUT_DATA_W'({
				(ctl.cnt_next == '0),
				ple_pkg::ENT_W'(ctl.cnt_next),
				ctl.status,
				value_out
			});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ple_pkg::OUT_BITS-1] ==
			(m_tdata[ple_pkg::VAL_W+2 +: ple_pkg::ENT_W] == '0))
		else $error("empty flag disagrees with entry count");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ctl.rd_en |=> m_tdata[ple_pkg::VAL_W-1:0] == '0)
		else $error("value out not zero for a non-read transaction");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted transaction lost its result");

endmodule
